[rtl/kmp_pkg.sv]
// Shared types and constants for the streaming prefix-table string matcher.
`default_nettype none

package kmp_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int POS_W       = 32;

   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_TEXT   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic             match_found;
      logic [POS_W-1:0] match_position;
      logic [1:0]       status;
   } rsp_type;

   // Finished result handed from the engine to the output stage.
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } done_type;

endpackage

`default_nettype wire

[rtl/kmp_stream_matcher_top.sv]
// Top level of the streaming prefix-table string matcher with its output register.
//
//   channel  direction  handshake               beat
//   req      in         req_valid / req_ready   action, data_byte
//   rsp      out        rsp_valid / rsp_ready   match_found, match_position, status
//
// Clear, append to an empty or full pattern, text on an empty pattern and unused
// actions finish in the cycle they are accepted. A text byte or an append to a
// non-empty pattern takes one test step plus one per prefix-table fallback: each step is
// one registered read of the pattern and prefix RAMs. Synchronous reset clears
// the lengths, match length and position; the RAMs need no clearing pass. While a
// result waits in the output register the next beat is still taken; the engine
// parks a second result and holds off input until the register drains.
`default_nettype none

module kmp_stream_matcher_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire kmp_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output kmp_pkg::rsp_type      rsp_payload
);

   import kmp_pkg::*;

   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;
   logic     slot_free;
   done_type done;

   // The register is free when empty or when its beat leaves this cycle.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   kmp_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_ready   (req_ready),
      .slot_free   (slot_free),
      .done        (done)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done.valid) begin
         // load a new beat; the engine only offers one when the slot is free
         rsp_valid_in = 1'b1;
         rsp_in       = done.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[rtl/kmp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/kmp_engine.sv]
// Sequencer: pattern append, prefix build and text matching over the two RAMs.
`default_nettype none

module kmp_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire kmp_pkg::req_type  req_payload,
   output logic                   req_ready,
   input  wire logic              slot_free,
   output kmp_pkg::done_type      done
);

   import kmp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TEST = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] build_ff, build_in;
   logic [LEN_W-1:0] match_ff, match_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] k_ff, k_in;
   logic [7:0]       c_ff, c_in;
   logic             text_ff, text_in;
   rsp_type          pend_ff, pend_in;

   logic [LEN_W-1:0] rd_k;
   logic [LEN_W-1:0] rd_km1;
   logic [7:0]       pat_rdata;
   logic [LEN_W-1:0] pref_rdata;
   logic             wr_en;
   logic [7:0]       wr_pat;
   logic [LEN_W-1:0] wr_pref;
   logic             fin;
   rsp_type          fin_rsp;
   logic             eq;
   logic             k_lt;
   logic [LEN_W-1:0] j;

   assign rd_km1    = rd_k - LEN_W'(1);
   assign req_ready = (state_ff == ST_IDLE);
   assign eq        = (pat_rdata == c_ff);
   assign k_lt      = (k_ff < len_ff);
   assign j         = (k_lt && eq) ? k_ff + LEN_W'(1) : k_ff;

   kmp_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pattern (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (wr_pat),
      .rd_addr (rd_k[IDX_W-1:0]),
      .rd_data (pat_rdata)
   );

   kmp_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERN)) u_prefix (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[IDX_W-1:0]),
      .wr_data (wr_pref),
      .rd_addr (rd_km1[IDX_W-1:0]),
      .rd_data (pref_rdata)
   );

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      build_in = build_ff;
      match_in = match_ff;
      pos_in   = pos_ff;
      k_in     = k_ff;
      c_in     = c_ff;
      text_in  = text_ff;
      pend_in  = pend_ff;
      rd_k     = k_ff;
      wr_en    = 1'b0;
      wr_pat   = c_ff;
      wr_pref  = '0;
      fin      = 1'b0;
      fin_rsp  = '0;
      done     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               c_in = req_payload.data_byte;
               case (req_payload.action)
                  ACT_CLEAR: begin
                     len_in   = '0;
                     build_in = '0;
                     match_in = '0;
                     pos_in   = '0;
                     fin      = 1'b1;
                  end
                  ACT_APPEND: begin
                     if (len_ff >= LEN_W'(MAX_PATTERN)) begin
                        fin_rsp.status = STATUS_FULL;
                        fin            = 1'b1;
                     end else if (len_ff == '0) begin
                        // first byte: prefix entry is zero, no search
                        wr_en    = 1'b1;
                        wr_pat   = req_payload.data_byte;
                        len_in   = LEN_W'(1);
                        build_in = '0;
                        fin      = 1'b1;
                     end else begin
                        text_in  = 1'b0;
                        k_in     = build_ff;
                        rd_k     = build_ff;
                        state_in = ST_TEST;
                     end
                  end
                  ACT_TEXT: begin
                     if (len_ff == '0) begin
                        fin_rsp.status = STATUS_EMPTY;
                        fin            = 1'b1;
                     end else begin
                        pos_in   = (pos_ff == '1) ? pos_ff : pos_ff + POS_W'(1);
                        text_in  = 1'b1;
                        k_in     = match_ff;
                        rd_k     = match_ff;
                        state_in = ST_TEST;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_TEST: begin
            if (k_ff == '0 || !k_lt || eq) begin
               fin = 1'b1;
               if (text_ff) begin
                  if (j == len_ff) begin
                     // full match: fall back to the last prefix entry
                     fin_rsp.match_found    = 1'b1;
                     fin_rsp.match_position = pos_ff - POS_W'(len_ff) + POS_W'(1);
                     match_in               = build_ff;
                  end else begin
                     match_in = j;
                  end
               end else begin
                  wr_en    = 1'b1;
                  wr_pref  = j;
                  build_in = j;
                  len_in   = len_ff + LEN_W'(1);
               end
            end else begin
               // mismatch: follow the prefix entry, read again next cycle
               k_in = pref_rdata;
               rd_k = pref_rdata;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               done.valid = 1'b1;
               done.rsp   = pend_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         if (slot_free) begin
            done.valid = 1'b1;
            done.rsp   = fin_rsp;
            state_in   = ST_IDLE;
         end else begin
            pend_in  = fin_rsp;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         build_ff <= '0;
         match_ff <= '0;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         build_ff <= build_in;
         match_ff <= match_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      c_ff    <= c_in;
      text_ff <= text_in;
      pend_ff <= pend_in;
   end

`ifndef NO_ASSERTIONS
   a_search_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) |-> (k_ff < len_ff))
      else $error("search index reached pattern length");

   a_match_below_len: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) |-> (match_ff < len_ff && build_ff < len_ff))
      else $error("match or build length not below pattern length");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (len_ff == '0) |-> (match_ff == '0 && build_ff == '0))
      else $error("stale match state with empty pattern");

   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (len_ff == $past(len_ff) + LEN_W'(1)))
      else $error("store write without pattern growth");
`endif

endmodule

`default_nettype wire
